// File: rtl/core/sha256_stream_hash_assert.svh
// Assertion macros for the SHA-256 stream hash checker.
`ifndef SHA256_STREAM_HASH_ASSERT_SVH
`define SHA256_STREAM_HASH_ASSERT_SVH
// Implication that must hold in the next cycle.
`define SHA_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
// Implication within the same cycle.
`define SHA_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
`endif

// File: rtl/core/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Constants and helper functions for the SHA-256 stream hash.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INITIAL_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef logic [31:0] word_type;

   // control from the sequencer to the round unit
   typedef struct packed {
      logic       start;   // load working variables from hash
      logic       round;   // run one round
      logic [5:0] t;       // round number
      logic       finish;  // add working variables into hash
      logic       init;    // reload initial hash
   } round_ctl_type;

   function automatic word_type rotr(word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

// File: rtl/core/sha256_stream_hash.sv
// Bytes are taken only in IDLE; a full block is compressed in the round unit (START,
// 64 ROUND steps, FINISH). End of message: padding one byte per cycle (up to 64+8
// bytes), one or two compressions, then eight digest words, one per accepted cycle.
// No byte is taken while a block runs through the 64-round loop of the shared
// round unit. Synchronous active-high reset restores the initial hash.
// ----------------------------------------------------------------------------
// sha256_stream_hash
// Byte-stream SHA-256: packs bytes, pads, sequences compressions, emits digest.
// ----------------------------------------------------------------------------
module sha256_stream_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   typedef enum logic [2:0] {IDLE, PAD, START, ROUND, FINISH, OUTPUT} state_type;

   state_type             state_ff, state_in;
   logic [60:0]           count_ff, count_in;
   logic [63:0]           bitlen_ff, bitlen_in;
   logic                  padding_ff, padding_in;
   logic [6:0]            pad_ff, pad_in;     // pad byte counter, jumps to 0x40 when the length bytes begin
   logic [5:0]            t_ff, t_in;
   logic [2:0]            idx_ff, idx_in;
   logic [31:0]           word_ff, word_in;
   logic                  push;
   logic [7:0]            push_byte;
   sha_pkg::round_ctl_type ctl;
   sha_pkg::word_type     rd_hash;
   logic [31:0]           packed_word;
   logic [1:0]            pos_lo;

   sha_round u_round (
      .clock(clock), .reset(reset), .ctl(ctl),
      .load_w(push && pos_lo == 2'd3), .load_idx(count_ff[5:2]),
      .load_data(packed_word), .rd_idx(idx_ff), .rd_hash(rd_hash)
   );

   assign pos_lo          = count_ff[1:0];
   assign req_ready       = (state_ff == IDLE);
   assign rsp_valid       = (state_ff == OUTPUT);
   assign rsp_digest_word = rd_hash;
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

   always_comb begin
      packed_word = {word_ff[31:8], push_byte};
      case (pos_lo)
         2'd0:    packed_word = {push_byte, 24'd0};
         2'd1:    packed_word = {word_ff[31:24], push_byte, 16'd0};
         2'd2:    packed_word = {word_ff[31:16], push_byte, 8'd0};
         default: packed_word = {word_ff[31:8], push_byte};
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      bitlen_in  = bitlen_ff;
      padding_in = padding_ff;
      pad_in     = pad_ff;
      t_in       = t_ff;
      idx_in     = idx_ff;
      word_in    = word_ff;
      push       = 1'b0;
      push_byte  = req_data_byte;
      ctl        = '0;
      ctl.t      = t_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               push = req_byte_present;
               if (req_end_of_message) begin
                  padding_in = 1'b1;
                  pad_in     = 7'd0;
                  bitlen_in  = {(req_byte_present ? count_ff + 61'd1 : count_ff), 3'd0};
               end
               if (req_byte_present && count_ff[5:0] == 6'd63) state_in = START;
               else if (req_end_of_message) state_in = PAD;
            end
         end
         PAD: begin
            push = 1'b1;
            if (pad_ff == 7'd0) push_byte = 8'h80;
            else if (count_ff[5:0] >= 6'd56 && pad_ff != 7'd0 &&
                     !(count_ff[5:0] == 6'd56 && pad_in == 7'd0))
               push_byte = 8'h00;
            else push_byte = 8'h00;
            // length bytes go in slots 56..63 once zero fill is done
            if (pad_ff[6] && count_ff[5:3] == 3'd7)
               push_byte = bitlen_ff[8*(7 - count_ff[2:0]) +: 8];
            pad_in = pad_ff + 7'd1;
            if (!pad_ff[6] && pad_ff != 7'd0 && count_ff[5:0] == 6'd56) begin
               // zero fill reached length slots: switch to length bytes
               pad_in    = 7'h40;
               push_byte = bitlen_ff[63:56];
            end else if (pad_ff == 7'd0 && count_ff[5:0] == 6'd55) begin
               pad_in = 7'h40;  // 0x80 lands on byte 55, length follows
            end
            if (count_ff[5:0] == 6'd63) state_in = START;
         end
         START: begin
            ctl.start = 1'b1;
            t_in      = 6'd0;
            state_in  = ROUND;
         end
         ROUND: begin
            ctl.round = 1'b1;
            t_in      = t_ff + 6'd1;
            if (t_ff == 6'd63) state_in = FINISH;
         end
         FINISH: begin
            ctl.finish = 1'b1;
            if (!padding_ff) state_in = IDLE;
            else if (pad_ff[6] && count_ff[5:0] == 6'd0) begin
               state_in = OUTPUT;
               idx_in   = 3'd0;
            end else state_in = PAD;
         end
         OUTPUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  state_in   = IDLE;
                  ctl.init   = 1'b1;
                  count_in   = '0;
                  padding_in = 1'b0;
               end
            end
         end
         default: state_in = IDLE;
      endcase
      if (push) begin
         word_in  = packed_word;
         count_in = count_ff + 61'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= IDLE;
         count_ff   <= '0;
         padding_ff <= 1'b0;
         pad_ff     <= '0;
         t_ff       <= '0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         padding_ff <= padding_in;
         pad_ff     <= pad_in;
         t_ff       <= t_in;
         idx_ff     <= idx_in;
      end
      bitlen_ff <= bitlen_in;
      word_ff   <= word_in;
   end
endmodule

// File: rtl/core/sha_round.sv
// ----------------------------------------------------------------------------
// sha_round
// Shared compression round: message schedule window, working variables and
// hash words, one round per cycle.
// ----------------------------------------------------------------------------
module sha_round (
   input  logic                   clock,
   input  logic                   reset,
   input  sha_pkg::round_ctl_type ctl,
   input  logic                   load_w,
   input  logic [3:0]             load_idx,
   input  sha_pkg::word_type      load_data,
   input  logic [2:0]             rd_idx,
   output sha_pkg::word_type      rd_hash
);
   sha_pkg::word_type w_ff [16];
   sha_pkg::word_type v_ff [8];
   sha_pkg::word_type h_ff [8];
   sha_pkg::word_type w_t, s0, s1, w_new, t1, t2, ch, maj;

   // window slot 0 always holds w[t]
   always_comb begin
      w_t   = w_ff[0];
      s0    = sha_pkg::rotr(w_ff[1], 7) ^ sha_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1    = sha_pkg::rotr(w_ff[14], 17) ^ sha_pkg::rotr(w_ff[14], 19)
              ^ (w_ff[14] >> 10);
      w_new = s1 + w_ff[9] + s0 + w_ff[0];
      ch    = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      maj   = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1    = v_ff[7] + (sha_pkg::rotr(v_ff[4], 6) ^ sha_pkg::rotr(v_ff[4], 11)
              ^ sha_pkg::rotr(v_ff[4], 25)) + ch + sha_pkg::ROUND_K[ctl.t] + w_t;
      t2    = (sha_pkg::rotr(v_ff[0], 2) ^ sha_pkg::rotr(v_ff[0], 13)
              ^ sha_pkg::rotr(v_ff[0], 22)) + maj;
   end

   assign rd_hash = h_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (load_w) begin
         w_ff[load_idx] <= load_data;
      end else if (ctl.round) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
      end
      if (ctl.start) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (ctl.round) begin
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
      if (reset || ctl.init) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= sha_pkg::INITIAL_HASH[i];
      end else if (ctl.finish) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
      end
   end
endmodule

// File: rtl/core/sha256_stream_hash_check.sv
// ----------------------------------------------------------------------------
// sha256_stream_hash_check
// Port-level checks on the digest sequence of the SHA-256 stream hash.
// ----------------------------------------------------------------------------
`include "sha256_stream_hash_assert.svh"
module sha256_stream_hash_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);
   // no word is taken while a digest is being drained
   `SHA_ASSERT_NOW(no_overlap, clock, reset, req_valid && req_ready, !rsp_valid)
   `SHA_ASSERT_NOW(last_flag, clock, reset, rsp_valid, rsp_last_word == (rsp_word_index == 3'd7))
   // stalled digest word holds
   `SHA_ASSERT_NEXT(hold_word, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_index))
   // digest words advance in order
   `SHA_ASSERT_NEXT(advance, clock, reset, rsp_valid && rsp_ready && !rsp_last_word,
      rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
endmodule

bind sha256_stream_hash sha256_stream_hash_check u_check (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_digest_word(rsp_digest_word),
   .rsp_word_index(rsp_word_index), .rsp_last_word(rsp_last_word)
);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the byte-stream SHA-256 hasher: every digest word is compared with
// a behavioral hash computed in the bench, under random flow control.
// ----------------------------------------------------------------------------
module tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_present = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_entry_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
      logic       known;          // digest typed in below
      logic [31:0] first_word;   // expected word 0 when known
   } stim_row_type;

   // model state
   logic [31:0] hash_state [8];
   logic [31:0] block_buf [16];
   logic [60:0] byte_count;

   digest_entry_type digest_queue [$];
   stim_row_type     directed_rows [$];
   logic [31:0]      known_first [$];
   logic             known_flag [$];

   int  error_count = 0;
   int  words_seen = 0;
   int  messages_sent = 0;
   int  idle_cycles = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_off = 1'b0;

   sha256_stream_hash uut (.*);

   always #6 clock = ~clock;

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void run_rounds();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2, ch, mj;
      for (int t = 0; t < 16; t++) w[t] = block_buf[t];
      for (int t = 16; t < 64; t++) begin
         s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      for (int t = 0; t < 8; t++) v[t] = hash_state[t];
      for (int t = 0; t < 64; t++) begin
         ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
         mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) + ch
              + sha_pkg::ROUND_K[t] + w[t];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) + mj;
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int t = 0; t < 8; t++) hash_state[t] = hash_state[t] + v[t];
   endfunction

   function automatic void absorb_byte(logic [7:0] b);
      int pos;
      pos = byte_count[5:0];
      if (pos[1:0] == 2'd0) block_buf[pos >> 2] = 32'h0;
      block_buf[pos >> 2][(3 - pos[1:0]) * 8 +: 8] = b;
      byte_count = byte_count + 61'd1;
      if (pos == 63) run_rounds();
   endfunction

   function automatic void restart_hash();
      for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::INITIAL_HASH[i];
      byte_count = '0;
   endfunction

   // Work out the digest words caused by one accepted word.
   function automatic void predict_digest(logic [7:0] b, logic present, logic eom);
      logic [63:0] bit_len;
      if (present) absorb_byte(b);
      if (eom) begin
         bit_len = {byte_count, 3'b000};
         absorb_byte(8'h80);
         while (byte_count[5:0] != 6'd56) absorb_byte(8'h00);
         for (int i = 0; i < 8; i++) absorb_byte(bit_len[(7 - i) * 8 +: 8]);
         for (int i = 0; i < 8; i++)
            digest_queue.push_back('{hash_state[i], 3'(i), i == 7});
         restart_hash();
      end
   endfunction

   // First digest word that the current message would give, for typed rows.
   function automatic logic [31:0] predict_peek(logic [7:0] b, logic present);
      logic [31:0] h_save [8];
      logic [31:0] blk_save [16];
      logic [60:0] cnt_save;
      digest_entry_type e;
      h_save = hash_state; blk_save = block_buf; cnt_save = byte_count;
      predict_digest(b, present, 1'b1);
      e = digest_queue.pop_back();
      for (int i = 0; i < 7; i++) e = digest_queue.pop_back();
      hash_state = h_save; block_buf = blk_save; byte_count = cnt_save;
      return e.digest_word;
   endfunction

   // Check digest words and predict from accepted request words.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (req_end_of_message) begin
               messages_sent++;
               if (known_flag.size() > 0) begin
                  if (known_flag[0]) begin
                     if (known_first[0] != predict_peek(req_data_byte,
                                                        req_byte_present)) begin
                        $display("%0t: typed digest mismatch expected %h actual %h",
                                 $time, known_first[0],
                                 predict_peek(req_data_byte, req_byte_present));
                        error_count++;
                     end
                  end
                  void'(known_flag.pop_front());
                  void'(known_first.pop_front());
               end
            end
            predict_digest(req_data_byte, req_byte_present, req_end_of_message);
         end
         if (rsp_valid && rsp_ready) begin
            words_seen++;
            if (digest_queue.size() == 0) begin
               $display("%0t: unexpected digest word expected none actual %h", $time,
                        rsp_digest_word);
               error_count++;
            end else begin
               digest_entry_type e;
               e = digest_queue.pop_front();
               if (e != {rsp_digest_word, rsp_word_index, rsp_last_word}) begin
                  $display("%0t: digest mismatch expected %h/%0d/%0d actual %h/%0d/%0d",
                           $time, e.digest_word, e.word_index, e.last_word,
                           rsp_digest_word, rsp_word_index, rsp_last_word);
                  error_count++;
               end
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset || hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog on cycles without any accepted word.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_word(logic [7:0] b, logic present, logic eom);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_byte_present <= present;
      req_end_of_message <= eom;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Wait at least one edge so the last accepted word is already predicted.
   task automatic drain_digests();
      do @(posedge clock); while (digest_queue.size() > 0);
   endtask

   task automatic send_message(int len);
      for (int i = 0; i < len; i++)
         send_word(8'($urandom), 1'b1, (i == len - 1));
      if (len == 0) send_word(8'($urandom), 1'b0, 1'b1);
   endtask

   initial begin
      int n;
      restart_hash();
      for (int i = 0; i < 16; i++) block_buf[i] = '0;
      // directed: empty, "abc", ignored bytes, extremes
      directed_rows = '{
         '{8'hff, 1'b0, 1'b1, 1'b1, 32'he3b0c442},
         '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
         '{8'hff, 1'b0, 1'b0, 1'b0, 32'h0},
         '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
         '{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf},
         '{8'h00, 1'b1, 1'b1, 1'b0, 32'h0},
         '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
         '{8'h55, 1'b0, 1'b0, 1'b0, 32'h0},
         '{8'haa, 1'b1, 1'b1, 1'b0, 32'h0}
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].end_of_message) begin
            known_flag.push_back(directed_rows[i].known);
            known_first.push_back(directed_rows[i].first_word);
         end
         send_word(directed_rows[i].data_byte, directed_rows[i].byte_present,
                   directed_rows[i].end_of_message);
      end
      // padding edge: 0x80 on byte 55, length right behind it
      send_message(55);
      req_valid <= 1'b0;
      drain_digests();
      // random phases of flow control
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 19 : 73) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 19 : 73) : 0;
         for (int m = 0; m < 3; m++) begin
            n = $urandom_range(4);
            for (int i = 0; i < n; i++)
               send_word(8'($urandom), $urandom_range(7) != 0, 1'b0);
            send_word(8'($urandom), 1'($urandom_range(1)), 1'b1);
         end
         req_valid <= 1'b0;
         drain_digests();   // sender pauses until all words are back
      end
      // long receiver hold-off while messages keep coming
      send_idle_pct = 0; recv_stall_pct = 0;
      hold_off = 1'b1;
      fork
         begin
            repeat (600) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            for (int m = 0; m < 4; m++) send_message($urandom_range(3));
            req_valid <= 1'b0;
         end
      join
      drain_digests();
      repeat (200) @(posedge clock);
      $display("Covered %0d messages, %0d digest words, padding edges and stalls",
               messages_sent, words_seen);
      if (error_count == 0 && digest_queue.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
